@@ rtl/bcf_pkg.sv @@
package bcf_pkg;

   localparam int FRAC_BITS = 16;
   localparam int POS_W     = 24;
   localparam int DIFF_W    = POS_W + 1;
   localparam int SQ_W      = 2 * DIFF_W;
   localparam int LEN_W     = SQ_W / 2;
   localparam int STR_W     = 25;
   localparam int KX_W      = POS_W + LEN_W;
   localparam int NUM_W     = KX_W + DIFF_W;
   localparam int Q_W       = KX_W;
   localparam int FORCE_W   = 32;
   localparam int KLO_W     = DIFF_W;
   localparam int KHI_W     = KX_W - KLO_W;
   localparam int SQ_STAGES  = LEN_W;
   localparam int DIV_STAGES = Q_W;
   // input reg, squares, sum, root load + stages, compare, k*x, partial products, combine,
   // divider load + stages, output
   localparam int LATENCY   = 3 + (SQ_STAGES + 1) + 4 + (DIV_STAGES + 1) + 1;

   typedef struct packed {
      logic [2:0]             neg;
      logic [2:0][DIFF_W-1:0] dabs;
      logic [POS_W-1:0]       rest;
      logic [POS_W-1:0]       k;
   } side_type;

   typedef struct packed {
      logic             stretched;
      logic [STR_W-1:0] stretch;
      logic [2:0]       neg;
      logic [LEN_W-1:0] len;
   } dside_type;

endpackage

@@ rtl/bungee_cord_force_core.sv @@
// Path: input, squares and sum registers, the square root, the compare, k*x, partial-product
// and combine registers, the divider and the output register; LATENCY in bcf_pkg sums them.
// Throughput: one request per cycle; busy stays low and every stage advances each cycle.
// Most of that depth lies in the 26-register square root (25 root bits) and the 50-register
// restoring divider (49 quotient bits).
// Reset (synchronous, active high) clears all valid bits; data registers are not reset.
// The receiver cannot stall: each result is shown for exactly one cycle.
module bungee_cord_force_core import bcf_pkg::*; (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_start,
   output logic                      busy,
   input  logic signed [POS_W-1:0]   req_a_x,
   input  logic signed [POS_W-1:0]   req_a_y,
   input  logic signed [POS_W-1:0]   req_a_z,
   input  logic signed [POS_W-1:0]   req_b_x,
   input  logic signed [POS_W-1:0]   req_b_y,
   input  logic signed [POS_W-1:0]   req_b_z,
   input  logic        [POS_W-1:0]   req_rest_length,
   input  logic        [POS_W-1:0]   req_stiffness,
   output logic                      rsp_valid,
   output logic                      rsp_stretched,
   output logic        [STR_W-1:0]   rsp_stretch,
   output logic signed [FORCE_W-1:0] rsp_force_x,
   output logic signed [FORCE_W-1:0] rsp_force_y,
   output logic signed [FORCE_W-1:0] rsp_force_z
);

   localparam logic [Q_W-1:0] POS_MAX = Q_W'(64'h7FFF_FFFF);
   localparam logic [Q_W-1:0] NEG_MAX = Q_W'(64'h8000_0000);

   assign busy = 1'b0;

   // stage 1: differences
   logic                           s1_v_ff;
   logic signed [2:0][DIFF_W-1:0]  s1_d_ff;
   logic [POS_W-1:0]               s1_rest_ff, s1_k_ff;

   // stage 2: magnitudes and squares
   logic                    s2_v_ff;
   logic [2:0][SQ_W-1:0]    s2_sq_ff;
   side_type                s2_side_ff;

   // stage 3: sum of squares
   logic                    s3_v_ff;
   logic [SQ_W-1:0]         s3_sum_ff;
   side_type                s3_side_ff;

   // square root pipeline, one root bit per stage
   logic                    rt_v_ff    [SQ_STAGES+1];
   logic [SQ_W-1:0]         rt_s_ff    [SQ_STAGES+1];
   logic [LEN_W+1:0]        rt_rem_ff  [SQ_STAGES+1];
   logic [LEN_W-1:0]        rt_root_ff [SQ_STAGES+1];
   side_type                rt_side_ff [SQ_STAGES+1];
   logic [SQ_W-1:0]         rt_s_in    [SQ_STAGES];
   logic [LEN_W+1:0]        rt_rem_in  [SQ_STAGES];
   logic [LEN_W-1:0]        rt_root_in [SQ_STAGES];

   // compare, k*x, partial products, combine
   logic                    p1_v_ff, p2_v_ff, p3_v_ff, p4_v_ff;
   dside_type               p1_ds_ff, p2_ds_ff, p3_ds_ff, p4_ds_ff;
   logic [POS_W-1:0]        p1_k_ff;
   logic [2:0][DIFF_W-1:0]  p1_dabs_ff, p2_dabs_ff;
   logic [KX_W-1:0]         p2_kx_ff;
   logic [2:0][KLO_W+DIFF_W-1:0] p3_lo_ff;
   logic [2:0][KHI_W+DIFF_W-1:0] p3_hi_ff;
   logic [2:0][NUM_W-1:0]   p4_num_ff;

   // divider pipeline: w holds remaining dividend bits above, quotient bits below
   logic                    dv_v_ff   [DIV_STAGES+1];
   dside_type               dv_ds_ff  [DIV_STAGES+1];
   logic [2:0][LEN_W-1:0]   dv_rem_ff [DIV_STAGES+1];
   logic [2:0][Q_W-1:0]     dv_w_ff   [DIV_STAGES+1];
   logic [2:0][LEN_W-1:0]   dv_rem_in [DIV_STAGES];
   logic [2:0][Q_W-1:0]     dv_w_in   [DIV_STAGES];

   logic                    p1_str_in;
   logic [LEN_W-1:0]        len_w;
   logic [2:0][FORCE_W-1:0] frc_in;

   always_comb begin
      for (int i = 0; i < SQ_STAGES; i++) begin
         logic [LEN_W+3:0] r2;
         logic [LEN_W+1:0] trial;
         r2    = {rt_rem_ff[i], rt_s_ff[i][SQ_W-1 -: 2]};
         trial = {rt_root_ff[i], 2'b01};
         rt_s_in[i] = {rt_s_ff[i][SQ_W-3:0], 2'b00};
         if (r2 >= {2'b00, trial}) begin
            rt_rem_in[i]  = (LEN_W+2)'(r2 - {2'b00, trial});
            rt_root_in[i] = {rt_root_ff[i][LEN_W-2:0], 1'b1};
         end else begin
            rt_rem_in[i]  = r2[LEN_W+1:0];
            rt_root_in[i] = {rt_root_ff[i][LEN_W-2:0], 1'b0};
         end
      end
   end

   always_comb begin
      for (int i = 0; i < DIV_STAGES; i++) begin
         for (int j = 0; j < 3; j++) begin
            logic [LEN_W:0] r2;
            r2 = {dv_rem_ff[i][j], dv_w_ff[i][j][Q_W-1]};
            if (r2 >= {1'b0, dv_ds_ff[i].len}) begin
               dv_rem_in[i][j] = LEN_W'(r2 - {1'b0, dv_ds_ff[i].len});
               dv_w_in[i][j]   = {dv_w_ff[i][j][Q_W-2:0], 1'b1};
            end else begin
               dv_rem_in[i][j] = r2[LEN_W-1:0];
               dv_w_in[i][j]   = {dv_w_ff[i][j][Q_W-2:0], 1'b0};
            end
         end
      end
   end

   assign len_w     = rt_root_ff[SQ_STAGES];
   assign p1_str_in = len_w > LEN_W'(rt_side_ff[SQ_STAGES].rest);

   always_comb begin
      for (int j = 0; j < 3; j++) begin
         logic [Q_W-1:0] f;
         f = dv_w_ff[DIV_STAGES][j] >> FRAC_BITS;
         if (!dv_ds_ff[DIV_STAGES].stretched) begin
            frc_in[j] = '0;
         end else if (dv_ds_ff[DIV_STAGES].neg[j]) begin
            frc_in[j] = (f > NEG_MAX) ? NEG_MAX[FORCE_W-1:0] : FORCE_W'(-f);
         end else begin
            frc_in[j] = (f > POS_MAX) ? POS_MAX[FORCE_W-1:0] : f[FORCE_W-1:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_v_ff   <= 1'b0;
         s2_v_ff   <= 1'b0;
         s3_v_ff   <= 1'b0;
         p1_v_ff   <= 1'b0;
         p2_v_ff   <= 1'b0;
         p3_v_ff   <= 1'b0;
         p4_v_ff   <= 1'b0;
         rsp_valid <= 1'b0;
         for (int i = 0; i <= SQ_STAGES; i++) rt_v_ff[i] <= 1'b0;
         for (int i = 0; i <= DIV_STAGES; i++) dv_v_ff[i] <= 1'b0;
      end else begin
         s1_v_ff   <= req_start && !busy;
         s2_v_ff   <= s1_v_ff;
         s3_v_ff   <= s2_v_ff;
         rt_v_ff[0] <= s3_v_ff;
         for (int i = 0; i < SQ_STAGES; i++) rt_v_ff[i+1] <= rt_v_ff[i];
         p1_v_ff   <= rt_v_ff[SQ_STAGES];
         p2_v_ff   <= p1_v_ff;
         p3_v_ff   <= p2_v_ff;
         p4_v_ff   <= p3_v_ff;
         dv_v_ff[0] <= p4_v_ff;
         for (int i = 0; i < DIV_STAGES; i++) dv_v_ff[i+1] <= dv_v_ff[i];
         rsp_valid <= dv_v_ff[DIV_STAGES];
      end
   end

   always_ff @(posedge clock) begin
      s1_d_ff[0] <= {req_a_x[POS_W-1], req_a_x} - {req_b_x[POS_W-1], req_b_x};
      s1_d_ff[1] <= {req_a_y[POS_W-1], req_a_y} - {req_b_y[POS_W-1], req_b_y};
      s1_d_ff[2] <= {req_a_z[POS_W-1], req_a_z} - {req_b_z[POS_W-1], req_b_z};
      s1_rest_ff <= req_rest_length;
      s1_k_ff    <= req_stiffness;

      for (int j = 0; j < 3; j++) begin
         logic [DIFF_W-1:0] m;
         m = s1_d_ff[j][DIFF_W-1] ? DIFF_W'(-s1_d_ff[j]) : s1_d_ff[j];
         s2_side_ff.neg[j]  <= s1_d_ff[j][DIFF_W-1];
         s2_side_ff.dabs[j] <= m;
         s2_sq_ff[j]        <= SQ_W'(m) * SQ_W'(m);
      end
      s2_side_ff.rest <= s1_rest_ff;
      s2_side_ff.k    <= s1_k_ff;

      s3_sum_ff  <= s2_sq_ff[0] + s2_sq_ff[1] + s2_sq_ff[2];
      s3_side_ff <= s2_side_ff;

      rt_s_ff[0]    <= s3_sum_ff;
      rt_rem_ff[0]  <= '0;
      rt_root_ff[0] <= '0;
      rt_side_ff[0] <= s3_side_ff;
      for (int i = 0; i < SQ_STAGES; i++) begin
         rt_s_ff[i+1]    <= rt_s_in[i];
         rt_rem_ff[i+1]  <= rt_rem_in[i];
         rt_root_ff[i+1] <= rt_root_in[i];
         rt_side_ff[i+1] <= rt_side_ff[i];
      end

      p1_ds_ff.stretched <= p1_str_in;
      p1_ds_ff.stretch   <= p1_str_in ? STR_W'(len_w - LEN_W'(rt_side_ff[SQ_STAGES].rest)) : '0;
      p1_ds_ff.neg       <= rt_side_ff[SQ_STAGES].neg;
      p1_ds_ff.len       <= len_w;
      p1_k_ff            <= rt_side_ff[SQ_STAGES].k;
      p1_dabs_ff         <= rt_side_ff[SQ_STAGES].dabs;

      p2_kx_ff   <= KX_W'(p1_k_ff) * KX_W'(p1_ds_ff.stretch);
      p2_ds_ff   <= p1_ds_ff;
      p2_dabs_ff <= p1_dabs_ff;

      // 49 x 25 product split into two narrow partial products
      for (int j = 0; j < 3; j++) begin
         p3_lo_ff[j] <= (KLO_W+DIFF_W)'(p2_kx_ff[KLO_W-1:0]) * (KLO_W+DIFF_W)'(p2_dabs_ff[j]);
         p3_hi_ff[j] <= (KHI_W+DIFF_W)'(p2_kx_ff[KX_W-1:KLO_W]) * (KHI_W+DIFF_W)'(p2_dabs_ff[j]);
      end
      p3_ds_ff <= p2_ds_ff;

      for (int j = 0; j < 3; j++)
         p4_num_ff[j] <= (NUM_W'(p3_hi_ff[j]) << KLO_W) + NUM_W'(p3_lo_ff[j]);
      p4_ds_ff <= p3_ds_ff;

      // numerator / 2^Q_W is below len since |d| <= len
      for (int j = 0; j < 3; j++) begin
         dv_rem_ff[0][j] <= p4_num_ff[j][NUM_W-1:Q_W];
         dv_w_ff[0][j]   <= p4_num_ff[j][Q_W-1:0];
      end
      dv_ds_ff[0] <= p4_ds_ff;
      for (int i = 0; i < DIV_STAGES; i++) begin
         dv_rem_ff[i+1] <= dv_rem_in[i];
         dv_w_ff[i+1]   <= dv_w_in[i];
         dv_ds_ff[i+1]  <= dv_ds_ff[i];
      end

      rsp_stretched <= dv_ds_ff[DIV_STAGES].stretched;
      rsp_stretch   <= dv_ds_ff[DIV_STAGES].stretch;
      rsp_force_x   <= frc_in[0];
      rsp_force_y   <= frc_in[1];
      rsp_force_z   <= frc_in[2];
   end

   a_latency: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(req_start && !busy, LATENCY))
      else $error("result without matching request");

   a_slack_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_stretched) |->
         (rsp_stretch == '0 && rsp_force_x == '0 && rsp_force_y == '0 && rsp_force_z == '0))
      else $error("slack cord with nonzero output");

   a_stretch_nz: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_stretched) |-> (rsp_stretch != '0))
      else $error("stretched cord with zero stretch");

endmodule

@@ sim/bcf_checker.sv @@
`timescale 1ns / 1ps

module bcf_checker import bcf_pkg::*; (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_start,
   input  logic                      busy,
   input  logic signed [POS_W-1:0]   req_a_x,
   input  logic signed [POS_W-1:0]   req_a_y,
   input  logic signed [POS_W-1:0]   req_a_z,
   input  logic signed [POS_W-1:0]   req_b_x,
   input  logic signed [POS_W-1:0]   req_b_y,
   input  logic signed [POS_W-1:0]   req_b_z,
   input  logic        [POS_W-1:0]   req_rest_length,
   input  logic        [POS_W-1:0]   req_stiffness,
   input  logic                      rsp_valid,
   input  logic                      rsp_stretched,
   input  logic        [STR_W-1:0]   rsp_stretch,
   input  logic signed [FORCE_W-1:0] rsp_force_x,
   input  logic signed [FORCE_W-1:0] rsp_force_y,
   input  logic signed [FORCE_W-1:0] rsp_force_z,
   output int                        errors,
   output int                        pending,
   output int                        n_taut,
   output int                        n_slack
);

   typedef struct packed {
      logic                      stretched;
      logic [STR_W-1:0]          stretch;
      logic signed [FORCE_W-1:0] fx;
      logic signed [FORCE_W-1:0] fy;
      logic signed [FORCE_W-1:0] fz;
   } cord_force_type;

   cord_force_type force_q[$];

   function automatic logic [63:0] int_sqrt(input logic [63:0] v);
      logic [63:0] r;
      logic [63:0] b;
      r = 0;
      b = 64'd1 << 62;
      while (b > v) b = b >> 2;
      while (b != 0) begin
         if (v >= r + b) begin
            v = v - (r + b);
            r = (r >> 1) + b;
         end else begin
            r = r >> 1;
         end
         b = b >> 2;
      end
      return r;
   endfunction

   function automatic logic signed [FORCE_W-1:0] axis_force(input logic [63:0] kx,
                                                            input longint d,
                                                            input logic [63:0] len);
      logic [127:0] mag;
      logic [127:0] q;
      mag = (d < 0) ? -d : d;
      q = ((kx * mag) / len) >> FRAC_BITS;
      if (d < 0) return (q > 128'h8000_0000) ? 32'sh8000_0000 : -q[31:0];
      return (q > 128'h7FFF_FFFF) ? 32'sh7FFF_FFFF : q[31:0];
   endfunction

   function automatic cord_force_type cord_force();
      cord_force_type f;
      longint dx, dy, dz;
      logic [63:0] len, x, kx;
      dx = longint'(req_a_x) - longint'(req_b_x);
      dy = longint'(req_a_y) - longint'(req_b_y);
      dz = longint'(req_a_z) - longint'(req_b_z);
      len = int_sqrt(dx*dx + dy*dy + dz*dz);
      f = '0;
      if (len > {40'd0, req_rest_length}) begin
         x = len - req_rest_length;
         kx = x * req_stiffness;
         f.stretched = 1'b1;
         f.stretch = x[STR_W-1:0];
         f.fx = axis_force(kx, dx, len);
         f.fy = axis_force(kx, dy, len);
         f.fz = axis_force(kx, dz, len);
      end
      return f;
   endfunction

   assign pending = force_q.size();

   always @(posedge clock) begin
      cord_force_type want, got;
      if (reset) begin
         errors <= 0;
         n_taut <= 0;
         n_slack <= 0;
      end else begin
         if (req_start && !busy) force_q.push_back(cord_force());
         if (rsp_valid) begin
            got = {rsp_stretched, rsp_stretch, rsp_force_x, rsp_force_y, rsp_force_z};
            if (force_q.size() == 0) begin
               errors <= errors + 1;
               if (errors < 10) $display("%t: unexpected result", $realtime);
            end else begin
               want = force_q.pop_front();
               if (want.stretched) n_taut <= n_taut + 1;
               else n_slack <= n_slack + 1;
               if (got !== want) begin
                  errors <= errors + 1;
                  if (errors < 10)
                     $display("%t: mismatch exp %0b %0d %0d %0d %0d got %0b %0d %0d %0d %0d",
                              $realtime, want.stretched, want.stretch, want.fx, want.fy,
                              want.fz, got.stretched, got.stretch, got.fx, got.fy, got.fz);
               end
            end
         end
      end
   end

endmodule

@@ sim/tb_bungee_cord_force_core.sv @@
`timescale 1ns / 1ps

module tb_bungee_cord_force_core import bcf_pkg::*; ();

   logic clock, reset, req_start, busy;
   logic signed [POS_W-1:0] req_a_x, req_a_y, req_a_z, req_b_x, req_b_y, req_b_z;
   logic [POS_W-1:0] req_rest_length, req_stiffness;
   logic rsp_valid, rsp_stretched;
   logic [STR_W-1:0] rsp_stretch;
   logic signed [FORCE_W-1:0] rsp_force_x, rsp_force_y, rsp_force_z;
   int errors, pending, n_taut, n_slack;

   bungee_cord_force_core dut (.*);
   bcf_checker checker_i (.*);

   initial begin
      clock = 0;
      forever #5 clock = ~clock;
   end

   initial begin
      #20ms;
      $display("simulation failed");
      $finish;
   end

   function automatic logic [23:0] rand_pos(input int mode);
      unique case (mode)
         0: return 24'($urandom);
         1: return 24'(int'($urandom_range(0, 4095)) - 2048);
         2: return $urandom_range(0, 1) ? 24'h7FFFFF : 24'h800000;
         default: return 24'(int'($urandom_range(0, 1 << 18)) - (1 << 17));
      endcase
   endfunction

   // one request; waits for acceptance, then drops start only if an idle gap follows
   task automatic send(input logic [23:0] ax, ay, az, bx, by, bz, rl, k, input int idle_pct);
      req_a_x <= ax; req_a_y <= ay; req_a_z <= az;
      req_b_x <= bx; req_b_y <= by; req_b_z <= bz;
      req_rest_length <= rl; req_stiffness <= k;
      req_start <= 1'b1;
      @(posedge clock);
      while (busy) @(posedge clock);
      @(negedge clock);
      if ($urandom_range(0, 99) < idle_pct) begin
         req_start <= 1'b0;
         repeat ($urandom_range(1, 4)) @(negedge clock);
      end
   endtask

   task automatic send_random(input int idle_pct);
      int m;
      logic [23:0] ax, ay, az, rl;
      m = $urandom_range(0, 3);
      ax = rand_pos(m); ay = rand_pos(m); az = rand_pos(m);
      rl = $urandom_range(0, 3) == 0 ? 24'($urandom) : 24'($urandom_range(0, 1 << 17));
      send(ax, ay, az, rand_pos(m), rand_pos(m), rand_pos(m), rl,
           $urandom_range(0, 3) == 0 ? 24'hFFFFFF : 24'($urandom), idle_pct);
   endtask

   task automatic drain;
      req_start <= 1'b0;
      while (pending != 0) @(negedge clock);
      repeat (LATENCY + 10) @(negedge clock);
   endtask

   initial begin
      reset = 1; req_start = 0;
      req_a_x = 0; req_a_y = 0; req_a_z = 0; req_b_x = 0; req_b_y = 0; req_b_z = 0;
      req_rest_length = 0; req_stiffness = 0;
      repeat (8) @(posedge clock);
      @(negedge clock);
      reset = 0;
      // directed: coincident ends, slack, extremes, saturation
      send(0, 0, 0, 0, 0, 0, 0, 24'hFFFFFF, 0);
      send(24'h010000, 0, 0, 0, 0, 0, 24'h010000, 24'h010000, 0);
      send(24'h020000, 0, 0, 0, 0, 0, 24'h010000, 24'h010000, 0);
      send(0, 24'h020000, 0, 0, 0, 0, 24'h010000, 24'h010000, 0);
      send(0, 0, 0, 0, 0, 24'h020000, 24'h010000, 24'h010000, 0);
      send(24'h7FFFFF, 24'h7FFFFF, 24'h7FFFFF, 24'h800000, 24'h800000, 24'h800000, 0,
           24'hFFFFFF, 0);
      send(24'h800000, 24'h800000, 24'h800000, 24'h7FFFFF, 24'h7FFFFF, 24'h7FFFFF, 0,
           24'hFFFFFF, 0);
      send(24'h7FFFFF, 24'h800000, 0, 24'h800000, 24'h7FFFFF, 0, 24'hFFFFFF, 24'hFFFFFF, 0);
      send(24'h7FFFFF, 0, 0, 24'h800000, 0, 0, 24'hFFFFFF, 24'hFFFFFF, 0);
      send(24'h7FFFFF, 0, 0, 24'h800000, 0, 0, 0, 0, 0);
      send(1, 0, 0, 0, 0, 0, 0, 24'hFFFFFF, 0);
      send(0, 0, 0, 1, 1, 1, 0, 1, 0);
      send(24'hFFFFFF, 24'h000001, 24'hFFFFFF, 24'h000001, 24'hFFFFFF, 24'h000001,
           1, 24'h800000, 0);
      drain();
      repeat (500) send_random(8);
      drain();  // sender holds until every result is back
      repeat (500) send_random(81);
      repeat (500) send_random(0);
      drain();
      $display("%0d stretched and %0d slack cords checked, %0d mismatches",
               n_taut, n_slack, errors);
      if (errors == 0)
         $display("simulation ok");
      else
         $display("simulation failed");
      $finish;
   end

endmodule
